[hdl/ddee_pkg.sv]
// shared types, byte codes and decimal helpers of the escape encoder
package ddee_pkg;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;  // '['
  localparam logic [7:0] CH_QUEST = 8'h3F;  // '?'
  localparam logic [7:0] CH_TWO   = 8'h32;  // '2'
  localparam logic [7:0] CH_FIVE  = 8'h35;  // '5'
  localparam logic [7:0] CH_LOW_L = 8'h6C;  // 'l'
  localparam logic [7:0] CH_LOW_H = 8'h68;  // 'h'
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_UP_H  = 8'h48;  // 'H'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

  localparam logic [6:0] COLUMNS_RESET = 7'd16;

  // one queued command: everything the back end sends for one item
  typedef struct packed {
    logic       home;      // ESC[H
    logic       hide;      // ESC[?25l
    logic       move;      // ESC[row;colH before the character
    logic [7:0] move_row;  // 1-based
    logic [7:0] move_col;  // 1-based
    logic       put_char;
    logic [7:0] ch;
    logic       show;      // ESC[?25h then cursor move
    logic [7:0] cur_row;   // 1-based
    logic [7:0] cur_col;   // 1-based
  } ddee_cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CMP,
    F_DIV,
    F_PUSH
  } ddee_front_state_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HOME,
    PH_HIDE,
    PH_MOVE,
    PH_CHAR,
    PH_SHOW
  } ddee_phase_t;

  // number of decimal digits of an 8-bit value
  function automatic logic [1:0] dec_len(input logic [7:0] v);
    if (v >= 8'd100) return 2'd3;
    else if (v >= 8'd10) return 2'd2;
    else return 2'd1;
  endfunction

  // ascii digit at position 0 hundreds, 1 tens, 2 ones
  function automatic logic [7:0] dec_digit(input logic [7:0] v, input logic [1:0] pos);
    logic [1:0]  hun;
    logic [7:0]  rem;
    logic [14:0] prod;
    logic [3:0]  ten;
    logic [7:0]  one;
    hun  = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    rem  = v - (8'(hun) * 8'd100);
    // divide by ten for values below 100
    prod = 15'(rem) * 15'd103;
    ten  = prod[13:10];
    one  = rem - (8'(ten) * 8'd10);
    case (pos)
      2'd0:    return CH_ZERO + 8'(hun);
      2'd1:    return CH_ZERO + 8'(ten);
      default: return CH_ZERO + one;
    endcase
  endfunction

  // byte count of ESC[row;colH
  function automatic logic [4:0] move_len(input logic [7:0] r, input logic [7:0] c);
    return 5'd4 + 5'(dec_len(r)) + 5'(dec_len(c));
  endfunction

  // byte k of ESC[row;colH
  function automatic logic [7:0] move_byte(input logic [4:0] k, input logic [7:0] r,
                                           input logic [7:0] c);
    logic [1:0] nr;
    logic [1:0] nc;
    logic [4:0] j;
    logic [4:0] m;
    nr = dec_len(r);
    nc = dec_len(c);
    j  = k - 5'd2;
    m  = j - 5'(nr) - 5'd1;
    if (k == 5'd0) return CH_ESC;
    else if (k == 5'd1) return CH_LBRK;
    else if (j < 5'(nr)) return dec_digit(r, 2'(5'd3 - 5'(nr) + j));
    else if (j == 5'(nr)) return CH_SEMI;
    else if (m < 5'(nc)) return dec_digit(c, 2'(5'd3 - 5'(nc) + m));
    else return CH_UP_H;
  endfunction

  // byte k of ESC[?25 followed by the closing letter
  function automatic logic [7:0] cursor_byte(input logic [4:0] k, input logic [7:0] tail);
    case (k)
      5'd0:    return CH_ESC;
      5'd1:    return CH_LBRK;
      5'd2:    return CH_QUEST;
      5'd3:    return CH_TWO;
      5'd4:    return CH_FIVE;
      default: return tail;
    endcase
  endfunction

  // first enabled phase after the given one
  function automatic ddee_phase_t next_phase(input ddee_phase_t p, input ddee_cmd_t c);
    logic [4:0] en;
    en = {c.show, c.put_char, c.move, c.hide, c.home};
    case (p)
      PH_IDLE: begin
        if (en[0]) return PH_HOME;
        else if (en[1]) return PH_HIDE;
        else if (en[2]) return PH_MOVE;
        else if (en[3]) return PH_CHAR;
        else if (en[4]) return PH_SHOW;
        else return PH_IDLE;
      end
      PH_HOME: begin
        if (en[1]) return PH_HIDE;
        else if (en[2]) return PH_MOVE;
        else if (en[3]) return PH_CHAR;
        else if (en[4]) return PH_SHOW;
        else return PH_IDLE;
      end
      PH_HIDE: begin
        if (en[2]) return PH_MOVE;
        else if (en[3]) return PH_CHAR;
        else if (en[4]) return PH_SHOW;
        else return PH_IDLE;
      end
      PH_MOVE: begin
        if (en[3]) return PH_CHAR;
        else if (en[4]) return PH_SHOW;
        else return PH_IDLE;
      end
      PH_CHAR: begin
        if (en[4]) return PH_SHOW;
        else return PH_IDLE;
      end
      default: return PH_IDLE;
    endcase
  endfunction

endpackage

[hdl/ddee_if.sv]
// valid/ready channel interfaces for cells in and bytes out
interface ddee_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        cell_char;
  logic              frame_start;
  logic              frame_end;
  logic signed [6:0] cursor_position;

  modport source (output valid, cell_char, frame_start, frame_end, cursor_position,
                  input ready);
  modport sink   (input valid, cell_char, frame_start, frame_end, cursor_position,
                  output ready);
endinterface

interface ddee_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_item;

  modport source (output valid, out_byte, last_of_item, input ready);
  modport sink   (input valid, out_byte, last_of_item, output ready);
endinterface

[hdl/ddee_front.sv]
// front end: accepts cells, compares with the display copy, builds commands
module ddee_front import ddee_pkg::*; #(
  parameter int MAX_CELLS = 64
) (
  input  logic           clk,
  input  logic           rst,
  ddee_in_if.sink        in_ch,
  input  logic [6:0]     columns,
  input  logic           q_full,
  output logic           q_push,
  output ddee_cmd_t      q_data
);

  localparam int CIW = $clog2(MAX_CELLS + 1);
  localparam int AW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  ddee_front_state_t state, state_next;

  // display copy
  logic [7:0] mem [MAX_CELLS];
  logic [7:0] rd_data;
  logic [AW-1:0] rd_addr;

  // frame state
  logic              shown_valid;
  logic signed [6:0] cursor_shown;
  logic signed [6:0] frame_cursor;
  logic              in_run;
  logic [CIW-1:0]    row_count;
  logic [6:0]        col_count;
  logic [CIW-1:0]    cell_index;
  logic              full_write;

  // held item
  logic [7:0] ch_q;
  logic       end_q;
  ddee_cmd_t  cmd;

  // cursor divider
  logic [6:0] div_rem;
  logic [4:0] div_quo;
  logic [5:0] div_dvd;
  logic [2:0] div_cnt;
  logic [7:0] div_trial;
  logic       div_ge;
  logic [6:0] div_rem_next;

  logic       accept;
  logic [6:0] cols_eff;
  logic       in_range;
  logic       col_wrap;
  logic       start_hide;
  logic       cmd_any;

  assign cols_eff    = (columns == 7'd0) ? 7'd1 : columns;
  assign in_ch.ready = (state == F_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign rd_addr     = in_ch.frame_start ? '0 : cell_index[AW-1:0];
  assign in_range    = (cell_index < CIW'(MAX_CELLS));
  assign col_wrap    = ({1'b0, col_count} + 8'd1) >= {1'b0, cols_eff};
  assign start_hide  = (in_ch.cursor_position != cursor_shown) || !in_ch.cursor_position[6];
  assign cmd_any     = cmd.home || cmd.hide || cmd.move || cmd.put_char || cmd.show;

  assign div_trial    = {div_rem, div_dvd[5]};
  assign div_ge       = div_trial >= {1'b0, cols_eff};
  assign div_rem_next = div_ge ? 7'(div_trial - {1'b0, cols_eff}) : div_trial[6:0];

  assign q_push = (state == F_PUSH) && cmd_any && !q_full;
  assign q_data = cmd;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (accept) state_next = F_CMP;
      F_CMP: begin
        if (end_q && !full_write && !frame_cursor[6]) state_next = F_DIV;
        else state_next = F_PUSH;
      end
      F_DIV:  if (div_cnt == 3'd5) state_next = F_PUSH;
      F_PUSH: if (!cmd_any || !q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // display copy read and write
  always_ff @(posedge clk) begin
    if (accept) rd_data <= mem[rd_addr];
    if (state == F_CMP && in_range) mem[cell_index[AW-1:0]] <= ch_q;
  end

  // frame control state
  always_ff @(posedge clk) begin
    if (rst) begin
      shown_valid  <= 1'b0;
      cursor_shown <= -7'sd1;
      frame_cursor <= -7'sd1;
      in_run       <= 1'b0;
      row_count    <= '0;
      col_count    <= '0;
      cell_index   <= '0;
      full_write   <= 1'b0;
    end else begin
      if (accept && in_ch.frame_start) begin
        frame_cursor <= in_ch.cursor_position;
        cell_index   <= '0;
        row_count    <= '0;
        col_count    <= '0;
        in_run       <= 1'b0;
        full_write   <= !shown_valid;
        if (shown_valid && start_hide) cursor_shown <= in_ch.cursor_position;
      end
      if (state == F_CMP) begin
        if (in_range) begin
          if (!full_write) in_run <= (rd_data != ch_q);
          cell_index <= cell_index + CIW'(1);
          if (col_wrap) begin
            col_count <= '0;
            row_count <= row_count + CIW'(1);
          end else begin
            col_count <= col_count + 7'd1;
          end
        end
        if (end_q && full_write) begin
          shown_valid <= 1'b1;
          full_write  <= 1'b0;
        end
      end
    end
  end

  // command build and cursor division
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_q         <= in_ch.cell_char;
      end_q        <= in_ch.frame_end;
      cmd.home     <= in_ch.frame_start && !shown_valid;
      cmd.hide     <= in_ch.frame_start && shown_valid && start_hide;
      cmd.move     <= 1'b0;
      cmd.put_char <= 1'b0;
      cmd.show     <= 1'b0;
    end
    if (state == F_CMP) begin
      cmd.ch       <= ch_q;
      cmd.move_row <= 8'(row_count) + 8'd1;
      cmd.move_col <= {1'b0, col_count} + 8'd1;
      if (in_range) begin
        if (full_write) begin
          cmd.put_char <= 1'b1;
        end else if (rd_data != ch_q) begin
          cmd.put_char <= 1'b1;
          cmd.move     <= !in_run;
        end
      end
      cmd.show <= end_q && !full_write && !frame_cursor[6];
      div_rem  <= '0;
      div_quo  <= '0;
      div_dvd  <= frame_cursor[5:0];
      div_cnt  <= '0;
    end
    if (state == F_DIV) begin
      div_rem <= div_rem_next;
      div_quo <= {div_quo[3:0], div_ge};
      div_dvd <= {div_dvd[4:0], 1'b0};
      div_cnt <= div_cnt + 3'd1;
      if (div_cnt == 3'd5) begin
        cmd.cur_row <= {2'b00, div_quo, div_ge} + 8'd1;
        cmd.cur_col <= {1'b0, div_rem_next} + 8'd1;
      end
    end
  end

endmodule

[hdl/ddee_fifo.sv]
// short command queue between front and back end
module ddee_fifo import ddee_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ddee_cmd_t push_data,
  output logic      full,
  input  logic      pop,
  output ddee_cmd_t pop_data,
  output logic      empty
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  ddee_cmd_t      slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;

  assign full     = (count == (PW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop) count <= count + (PW+1)'(1);
      else if (pop && !push) count <= count - (PW+1)'(1);
    end
  end

endmodule

[hdl/ddee_back.sv]
// back end: expands queued commands into escape bytes, one per cycle while the receiver is ready
module ddee_back import ddee_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  ddee_cmd_t  q_data,
  output logic       q_pop,
  ddee_out_if.source out_ch
);

  ddee_phase_t phase, phase_next;
  logic [4:0]  sub, sub_next;
  ddee_cmd_t   cmd;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;

  logic [7:0]  byte_now;
  logic [4:0]  phase_len;
  logic        at_end;
  ddee_phase_t after;
  logic        advance;

  assign out_ch.valid        = out_valid;
  assign out_ch.out_byte     = out_byte;
  assign out_ch.last_of_item = out_last;

  assign q_pop   = (phase == PH_IDLE) && !q_empty;
  assign advance = (phase != PH_IDLE) && (!out_valid || out_ch.ready);
  assign at_end  = (sub == phase_len - 5'd1);
  assign after   = next_phase(phase, cmd);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      sub   <= '0;
    end else begin
      phase <= phase_next;
      sub   <= sub_next;
    end
  end

  // byte selection, phase length and next state
  always_comb begin
    byte_now  = cmd.ch;
    phase_len = 5'd1;
    case (phase)
      PH_HOME: begin
        phase_len = 5'd3;
        byte_now  = (sub == 5'd0) ? CH_ESC : ((sub == 5'd1) ? CH_LBRK : CH_UP_H);
      end
      PH_HIDE: begin
        phase_len = 5'd6;
        byte_now  = cursor_byte(sub, CH_LOW_L);
      end
      PH_MOVE: begin
        phase_len = move_len(cmd.move_row, cmd.move_col);
        byte_now  = move_byte(sub, cmd.move_row, cmd.move_col);
      end
      PH_CHAR: begin
        phase_len = 5'd1;
        byte_now  = cmd.ch;
      end
      PH_SHOW: begin
        phase_len = 5'd6 + move_len(cmd.cur_row, cmd.cur_col);
        byte_now  = (sub < 5'd6) ? cursor_byte(sub, CH_LOW_H)
                                 : move_byte(sub - 5'd6, cmd.cur_row, cmd.cur_col);
      end
      default: begin
        phase_len = 5'd1;
        byte_now  = cmd.ch;
      end
    endcase

    phase_next = phase;
    sub_next   = sub;
    if (q_pop) begin
      phase_next = next_phase(PH_IDLE, q_data);
      sub_next   = '0;
    end else if (advance) begin
      if (at_end) begin
        phase_next = after;
        sub_next   = '0;
      end else begin
        sub_next = sub + 5'd1;
      end
    end
  end

  // command register
  always_ff @(posedge clk) begin
    if (q_pop) cmd <= q_data;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= byte_now;
      out_last <= at_end && (after == PH_IDLE);
    end
  end

endmodule

[hdl/display_diff_escape_encoder.sv]
// Differential ANSI screen update encoder, top level.
// Front end takes a new cell only when done with the last, waiting while the queue is full;
// a frame's last cell with a visible cursor also goes through a six-step divide of the cursor
// index by the row width. Back end sends one byte per cycle while the receiver is ready and
// pauses to load each command. A 4-deep command queue sits between the two.
// Reset: control state cleared, columns back to 16; the display copy is not cleared and the
// first frame after reset is sent whole.
module display_diff_escape_encoder import ddee_pkg::*; #(
  parameter int MAX_CELLS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  ddee_in_if.sink    in_ch,
  ddee_out_if.source out_ch
);

  logic [6:0] columns;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  ddee_cmd_t  q_wdata;
  ddee_cmd_t  q_rdata;

  // row width register
  always_ff @(posedge clk) begin
    if (rst) columns <= COLUMNS_RESET;
    else if (cfg_wr_en) columns <= cfg_wr_data;
  end

  ddee_front #(.MAX_CELLS(MAX_CELLS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .columns (columns),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  ddee_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  ddee_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[tb/ddee_stream_checker.sv]
`timescale 1ns / 100ps
// escape encoder checker: predicts the byte stream from accepted cells and compares
module ddee_stream_checker import ddee_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  ddee_in_if         in_ch,
  ddee_out_if        out_ch,
  output int         fail_count,
  output int         pending,
  output int         bytes_seen
);

  localparam int SCREEN_CELLS = 64;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] code;
    logic       tail;
  } stream_byte_t;

  // bytes still owed by the block, oldest first
  stream_byte_t stream_due[$];
  // bytes caused by the cell being predicted
  logic [7:0]   cell_bytes[$];

  // our copy of what the display shows
  logic [7:0] screen_copy [SCREEN_CELLS];
  bit         screen_valid;
  bit         full_frame;
  bit         run_open;
  int         cur_on_screen;
  int         cur_of_frame;
  int         cell_pos;
  int         row_pos;
  int         col_pos;
  logic [6:0] row_width;

  int           errs;
  int           checked;
  stream_byte_t due;

  // decimal without leading zeros
  function automatic void put_dec(input int v);
    if (v >= 100) cell_bytes.push_back(CH_ZERO + 8'((v / 100) % 10));
    if (v >= 10) cell_bytes.push_back(CH_ZERO + 8'((v / 10) % 10));
    cell_bytes.push_back(CH_ZERO + 8'(v % 10));
  endfunction

  // ESC[row;colH, 1-based
  function automatic void put_move(input int row, input int col);
    cell_bytes.push_back(CH_ESC);
    cell_bytes.push_back(CH_LBRK);
    put_dec(row + 1);
    cell_bytes.push_back(CH_SEMI);
    put_dec(col + 1);
    cell_bytes.push_back(CH_UP_H);
  endfunction

  // ESC[?25 with l to hide or h to show
  function automatic void put_cursor(input logic [7:0] tail);
    cell_bytes.push_back(CH_ESC);
    cell_bytes.push_back(CH_LBRK);
    cell_bytes.push_back(CH_QUEST);
    cell_bytes.push_back(CH_TWO);
    cell_bytes.push_back(CH_FIVE);
    cell_bytes.push_back(tail);
  endfunction

  // work out the bytes one accepted cell causes and queue them
  function automatic void encode_cell(input logic [7:0] ch, input logic st, input logic fin,
                                      input logic signed [6:0] cur);
    int width;
    width = (row_width == 7'd0) ? 1 : int'(row_width);
    cell_bytes.delete();

    // frame start: home for the first frame, else hide when needed
    if (st) begin
      cur_of_frame = int'(cur);
      cell_pos     = 0;
      row_pos      = 0;
      col_pos      = 0;
      run_open     = 1'b0;
      full_frame   = !screen_valid;
      if (full_frame) begin
        cell_bytes.push_back(CH_ESC);
        cell_bytes.push_back(CH_LBRK);
        cell_bytes.push_back(CH_UP_H);
      end else if (cur_of_frame != cur_on_screen || cur_of_frame >= 0) begin
        put_cursor(CH_LOW_L);
        cur_on_screen = cur_of_frame;
      end
    end

    // the cell itself, dropped past the end of the screen
    if (cell_pos < SCREEN_CELLS) begin
      if (full_frame) begin
        cell_bytes.push_back(ch);
      end else if (screen_copy[cell_pos] != ch) begin
        if (!run_open) put_move(row_pos, col_pos);
        run_open = 1'b1;
        cell_bytes.push_back(ch);
      end else begin
        run_open = 1'b0;
      end
      screen_copy[cell_pos] = ch;
      cell_pos++;
      if (col_pos + 1 >= width) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
    end

    // frame end: leave full-write mode or show the cursor
    if (fin) begin
      if (full_frame) begin
        screen_valid = 1'b1;
        full_frame   = 1'b0;
      end else if (cur_of_frame >= 0) begin
        put_cursor(CH_LOW_H);
        put_move(cur_of_frame / width, cur_of_frame % width);
      end
    end

    foreach (cell_bytes[k])
      stream_due.push_back(stream_byte_t'{cell_bytes[k], k == cell_bytes.size() - 1});
  endfunction

  // watch config, cells in and bytes out
  always @(posedge clk) begin
    if (rst) begin
      stream_due.delete();
      screen_valid  = 1'b0;
      full_frame    = 1'b0;
      run_open      = 1'b0;
      cur_on_screen = -1;
      cur_of_frame  = -1;
      cell_pos      = 0;
      row_pos       = 0;
      col_pos       = 0;
      row_width     = COLUMNS_RESET;
    end else begin
      if (cfg_wr_en === 1'b1) row_width = cfg_wr_data;
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        encode_cell(in_ch.cell_char, in_ch.frame_start, in_ch.frame_end,
                    in_ch.cursor_position);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (stream_due.size() == 0) begin
          errs++;
          if (errs <= REPORT_LIMIT)
            $display("byte %0d: got %02h last %0b with nothing due", checked,
                     out_ch.out_byte, out_ch.last_of_item);
        end else begin
          due = stream_due.pop_front();
          if (out_ch.out_byte !== due.code || out_ch.last_of_item !== due.tail) begin
            errs++;
            if (errs <= REPORT_LIMIT)
              $display("byte %0d: expected %02h last %0b, got %02h last %0b", checked,
                       due.code, due.tail, out_ch.out_byte, out_ch.last_of_item);
          end
        end
        checked++;
      end
    end
    fail_count <= errs;
    pending    <= stream_due.size();
    bytes_seen <= checked;
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// escape encoder testbench top: clock, reset, cell stimulus, output stalls and verdict
module tb_top import ddee_pkg::*; ();

  localparam int SCREEN_CELLS  = 64;
  localparam int RANDOM_CELLS  = 150;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 600000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_CHOKE,
    RX_PULSE
  } rx_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en;
  logic [6:0] cfg_wr_data;
  int         fail_count;
  int         pending;
  int         bytes_seen;

  ddee_in_if  in_ch ();
  ddee_out_if out_ch ();

  display_diff_escape_encoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  ddee_stream_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .bytes_seen  (bytes_seen)
  );

  // what the display holds, so the stimulus can repeat or change cells on purpose
  logic [7:0] screen_shadow [SCREEN_CELLS];
  int         shadow_pos  = 0;
  int         burst_left  = 0;
  int         cells_sent  = 0;
  int         frames_sent = 0;
  int         widths_set  = 0;
  int         cycle_count = 0;
  rx_mode_t   rx_mode     = RX_OPEN;
  int         rx_left     = 0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stalls, switching between patterns
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:  out_ch.ready <= 1'b1;
        RX_COIN:  out_ch.ready <= ($urandom_range(0, 1) == 1);
        RX_CHOKE: out_ch.ready <= ($urandom_range(0, 7) == 0);
        default:  out_ch.ready <= ((cycle_count % 6) < 3);
      endcase
    end
  end

  // char that differs from the stored one at the cell about to go
  function automatic logic [7:0] differ_char(input bit st, input logic [7:0] want);
    int idx;
    idx = st ? 0 : shadow_pos;
    if (idx < SCREEN_CELLS && screen_shadow[idx] == want) return ~want;
    return want;
  endfunction

  // char equal to the stored one at the cell about to go
  function automatic logic [7:0] same_char(input bit st);
    int idx;
    idx = st ? 0 : shadow_pos;
    if (idx < SCREEN_CELLS) return screen_shadow[idx];
    return 8'($urandom_range(0, 255));
  endfunction

  // offer one item, wait for it to be taken, then maybe a gap
  task automatic send_cell(input logic [7:0] ch, input bit st, input bit fin, input int cur);
    if (st) begin
      shadow_pos = 0;
      frames_sent++;
    end
    if (shadow_pos < SCREEN_CELLS) begin
      screen_shadow[shadow_pos] = ch;
      shadow_pos++;
    end
    in_ch.valid           <= 1'b1;
    in_ch.cell_char       <= ch;
    in_ch.frame_start     <= st;
    in_ch.frame_end       <= fin;
    in_ch.cursor_position <= 7'(cur);
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    cells_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end
  endtask

  // one frame of random content, part of it repeating the display
  task automatic send_frame(input int len, input int cur, input int same_pct, input bit with_end);
    bit         st;
    logic [7:0] ch;
    for (int i = 0; i < len; i++) begin
      st = (i == 0);
      if ($urandom_range(0, 99) < same_pct) begin
        ch = same_char(st);
      end else begin
        case ($urandom_range(0, 5))
          0:       ch = 8'h00;
          1:       ch = 8'hFF;
          default: ch = 8'($urandom_range(0, 255));
        endcase
      end
      send_cell(ch, st, with_end && (i == len - 1), st ? cur : int'($urandom_range(0, 127)));
    end
  endtask

  // stop sending and wait until every byte has come out and the block is quiet
  task automatic settle_stream();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // row width write, only with the block idle
  task automatic set_columns(input logic [6:0] w);
    settle_stream();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    widths_set++;
  endtask

  initial begin
    int         goal;
    int         kind;
    int         len;
    int         cur;
    int         pick;
    int         plan_step;
    int         phase_left;
    int         start_count;
    bit         phase_fresh;
    logic [6:0] next_width;

    in_ch.valid           <= 1'b0;
    in_ch.cell_char       <= 8'h00;
    in_ch.frame_start     <= 1'b0;
    in_ch.frame_end       <= 1'b0;
    in_ch.cursor_position <= 7'd0;
    cfg_wr_en             <= 1'b0;
    cfg_wr_data           <= COLUMNS_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first frame is a full write and fills the whole display copy
    for (int i = 0; i < SCREEN_CELLS; i++)
      send_cell((i == 0) ? 8'h00 : ((i == SCREEN_CELLS - 1) ? 8'hFF : 8'($urandom_range(0, 255))),
                i == 0, i == SCREEN_CELLS - 1, 5);

    // hidden cursor unchanged: two runs, no hide, no show
    send_cell(same_char(1), 1, 0, -1);
    send_cell(differ_char(0, 8'h00), 0, 0, 3);
    send_cell(differ_char(0, 8'hFF), 0, 0, 100);
    send_cell(same_char(0), 0, 0, 0);
    send_cell(differ_char(0, 8'h41), 0, 1, 127);
    // visible cursor at the last cell
    send_cell(differ_char(1, 8'hFF), 1, 0, 63);
    send_cell(differ_char(0, 8'h7E), 0, 0, 0);
    send_cell(same_char(0), 0, 1, 0);
    // single-cell frames with both flags
    send_cell(same_char(1), 1, 1, 0);
    send_cell(differ_char(1, 8'h20), 1, 1, -64);
    send_cell(same_char(1), 1, 1, -1);
    // cells with no frame start carry on after the frame end
    send_cell(differ_char(0, 8'h55), 0, 0, 64);
    send_cell(same_char(0), 0, 0, 33);
    send_cell(differ_char(0, 8'hAA), 0, 1, 96);
    // width extremes, zero acting as one
    set_columns(7'd0);
    send_frame(3, 5, 0, 1);
    set_columns(7'd127);
    send_frame(2, 63, 0, 1);
    set_columns(7'd1);
    send_frame(1, 63, 0, 1);
    set_columns(7'd64);
    send_frame(2, 63, 50, 1);

    // random frames in phases of one row width each
    goal        = cells_sent + RANDOM_CELLS;
    plan_step   = 0;
    phase_left  = 0;
    phase_fresh = 1'b0;
    while (cells_sent < goal) begin
      if (phase_left <= 0) begin
        case (plan_step)
          0:       next_width = 7'd16;
          1:       next_width = 7'd1;
          2:       next_width = 7'd64;
          3:       next_width = 7'd0;
          4:       next_width = 7'd127;
          default: next_width = 7'($urandom_range(1, 64));
        endcase
        plan_step++;
        set_columns(next_width);
        phase_left  = $urandom_range(25, 50);
        phase_fresh = 1'b1;
      end
      start_count = cells_sent;
      kind = (phase_fresh && plan_step <= 2) ? 10 : $urandom_range(0, 99);
      phase_fresh = 1'b0;
      if (kind < 8) begin
        // stray cells outside any frame start
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          send_cell(8'($urandom_range(0, 255)), 0, $urandom_range(0, 3) == 0,
                    $urandom_range(0, 127));
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 11) cur = $urandom_range(0, 63);
        else if (pick < 17) cur = -1;
        else cur = -int'($urandom_range(2, 64));
        // a few frames run past the end of the screen
        len = (kind < 14) ? $urandom_range(64, 72) : $urandom_range(1, 16);
        send_frame(len, cur, $urandom_range(0, 90), $urandom_range(0, 9) != 0);
      end
      phase_left -= cells_sent - start_count;
    end

    settle_stream();
    $display("covered %0d cells in %0d frames under %0d row width settings",
             cells_sent, frames_sent, widths_set);
    $display("compared %0d output bytes, %0d failures", bytes_seen, fail_count);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
